// File: hw/rtl/esds_pkg.sv
// ----------------------------------------------------------------------------
// esds_pkg
// Shared types and constants of the descriptor parser: the job handed from the
// byte parser to the config decoder, descriptor tags and the rate table.
// ----------------------------------------------------------------------------
package esds_pkg;

  // Bytes of the audio config that the decoder can ever reach (51 bits max).
  localparam int unsigned HEAD_BYTES = 7;
  localparam int unsigned HEAD_BITS  = 8 * HEAD_BYTES;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] TAG_ES  = 8'h03;
  localparam logic [7:0] TAG_DC  = 8'h04;
  localparam logic [7:0] TAG_CFG = 8'h05;

  localparam logic [7:0] ES_FLAG_DEP = 8'h80;
  localparam logic [7:0] ES_FLAG_URL = 8'h40;
  localparam logic [7:0] ES_FLAG_OCR = 8'h20;

  localparam logic [4:0]  AOT_ESCAPE = 5'd31;
  localparam logic [4:0]  AOT_SBR    = 5'd5;
  localparam logic [4:0]  AOT_PS     = 5'd29;
  localparam logic [4:0]  AOT_LC_MAX = 5'd4;
  localparam logic [10:0] SYNC_EXT   = 11'h2B7;

  typedef struct packed {
    logic                 ok;
    logic [LEN_W-1:0]     len;
    logic [HEAD_BITS-1:0] head;
  } job_t;

  function automatic logic [16:0] rate_of(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/esds_in_if.sv
// ----------------------------------------------------------------------------
// esds_in_if
// Byte channel into the parser: one payload byte and its end marker.
// ----------------------------------------------------------------------------
interface esds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/esds_out_if.sv
// ----------------------------------------------------------------------------
// esds_out_if
// Result channel of the parser: decoded audio config, one per payload.
// ----------------------------------------------------------------------------
interface esds_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [6:0]  object_type;
  logic [16:0] output_rate_hz;
  logic [1:0]  channel_count;
  logic        sbr_present;
  logic [6:0]  config_length;

  modport source (output valid, output status, output object_type, output output_rate_hz,
                  output channel_count, output sbr_present, output config_length,
                  input ready);
  modport sink   (input valid, input status, input object_type, input output_rate_hz,
                  input channel_count, input sbr_present, input config_length,
                  output ready);
endinterface

// File: hw/rtl/esds_front.sv
// ----------------------------------------------------------------------------
// esds_front
// Byte parser: walks the descriptor tree one byte per cycle while byte_fire_i
// is high, captures the config head and queues a decode job on the last byte.
// ----------------------------------------------------------------------------
module esds_front #(
  parameter int unsigned MAX_CONFIG_BYTES = 64,
  parameter int unsigned MAX_DESCRIPTORS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_fire_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          push_o,
  output esds_pkg::job_t job_o
);
  import esds_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_CONFIG_BYTES + 1);
  localparam int unsigned DCNT_W = $clog2(MAX_DESCRIPTORS + 1);
  localparam int unsigned HIDX_W = $clog2(HEAD_BYTES);

  typedef enum logic [3:0] {
    PH_SKIP, PH_TAG, PH_LEN_ES, PH_LEN_DC, PH_LEN_CFG, PH_LEN_OTHER,
    PH_ES_ID, PH_ES_FLAGS, PH_ES_DEP, PH_ES_URLLEN, PH_ES_URL, PH_ES_OCR,
    PH_CAPTURE, PH_DONE, PH_FAIL
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [31:0]        skip_q, skip_d;
  logic [31:0]        acc_q, acc_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [7:0]         flags_q, flags_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [7:0]         head_q [HEAD_BYTES];
  logic [7:0]         head_d [HEAD_BYTES];
  logic               skip_end;

  assign skip_end = (skip_q == 32'd1);

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    flags_d = flags_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    head_d  = head_q;
    push_o  = 1'b0;
    job_o   = '0;

    if (byte_fire_i) begin
      case (phase_q)
        PH_SKIP, PH_ES_ID, PH_ES_DEP, PH_ES_URL, PH_ES_OCR: begin
          skip_d = skip_q - 32'd1;
          if (skip_end) begin
            case (phase_q)
              PH_ES_ID: phase_d = PH_ES_FLAGS;
              PH_ES_DEP: begin
                if ((flags_q & ES_FLAG_URL) != '0) begin
                  phase_d = PH_ES_URLLEN;
                end else if ((flags_q & ES_FLAG_OCR) != '0) begin
                  skip_d  = 32'd2;
                  phase_d = PH_ES_OCR;
                end else begin
                  phase_d = PH_TAG;
                end
              end
              PH_ES_URL: begin
                if ((flags_q & ES_FLAG_OCR) != '0) begin
                  skip_d  = 32'd2;
                  phase_d = PH_ES_OCR;
                end else begin
                  phase_d = PH_TAG;
                end
              end
              default: phase_d = PH_TAG;
            endcase
          end
        end
        PH_TAG: begin
          if (dcnt_q >= DCNT_W'(MAX_DESCRIPTORS)) begin
            phase_d = PH_FAIL;
          end else begin
            dcnt_d = dcnt_q + 1'b1;
            acc_d  = '0;
            case (data_byte_i)
              TAG_ES:  phase_d = PH_LEN_ES;
              TAG_DC:  phase_d = PH_LEN_DC;
              TAG_CFG: phase_d = PH_LEN_CFG;
              default: phase_d = PH_LEN_OTHER;
            endcase
          end
        end
        PH_LEN_ES, PH_LEN_DC, PH_LEN_CFG, PH_LEN_OTHER: begin
          acc_d = {acc_q[24:0], data_byte_i[6:0]};
          if (!data_byte_i[7]) begin
            case (phase_q)
              PH_LEN_ES: begin
                skip_d  = 32'd2;
                phase_d = PH_ES_ID;
              end
              PH_LEN_DC: begin
                skip_d  = 32'd13;
                phase_d = PH_SKIP;
              end
              PH_LEN_CFG: begin
                if (acc_d == '0 || acc_d > 32'(MAX_CONFIG_BYTES)) begin
                  phase_d = PH_FAIL;
                end else begin
                  len_d   = CNT_W'(acc_d);
                  cnt_d   = '0;
                  phase_d = PH_CAPTURE;
                end
              end
              default: begin
                if (acc_d == '0) begin
                  phase_d = PH_TAG;
                end else begin
                  skip_d  = acc_d;
                  phase_d = PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_ES_FLAGS: begin
          flags_d = data_byte_i;
          if ((data_byte_i & ES_FLAG_DEP) != '0) begin
            skip_d  = 32'd2;
            phase_d = PH_ES_DEP;
          end else if ((data_byte_i & ES_FLAG_URL) != '0) begin
            phase_d = PH_ES_URLLEN;
          end else if ((data_byte_i & ES_FLAG_OCR) != '0) begin
            skip_d  = 32'd2;
            phase_d = PH_ES_OCR;
          end else begin
            phase_d = PH_TAG;
          end
        end
        PH_ES_URLLEN: begin
          if (data_byte_i != '0) begin
            skip_d  = 32'(data_byte_i);
            phase_d = PH_ES_URL;
          end else if ((flags_q & ES_FLAG_OCR) != '0) begin
            skip_d  = 32'd2;
            phase_d = PH_ES_OCR;
          end else begin
            phase_d = PH_TAG;
          end
        end
        PH_CAPTURE: begin
          if (cnt_q < CNT_W'(HEAD_BYTES)) begin
            head_d[cnt_q[HIDX_W-1:0]] = data_byte_i;
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_d >= len_q) begin
            done_d  = 1'b1;
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase

      if (last_byte_i) begin
        push_o    = 1'b1;
        job_o.ok  = done_d;
        job_o.len = LEN_W'(len_d);
        for (int i = 0; i < HEAD_BYTES; i++) begin
          job_o.head[HEAD_BITS-1-8*i -: 8] = head_d[i];
        end
        phase_d = PH_SKIP;
        skip_d  = 32'd4;
        acc_d   = '0;
        dcnt_d  = '0;
        flags_d = '0;
        len_d   = '0;
        cnt_d   = '0;
        done_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      skip_q  <= 32'd4;
      acc_q   <= '0;
      dcnt_q  <= '0;
      flags_q <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

endmodule

// File: hw/rtl/esds_job_fifo.sv
// ----------------------------------------------------------------------------
// esds_job_fifo
// Two-entry queue of decode jobs between the byte parser and the decoder.
// ----------------------------------------------------------------------------
module esds_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  esds_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output esds_pkg::job_t pop_data_o
);
  import esds_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  job_t                     mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]         wr_q, rd_q;
  logic [$clog2(FIFO_DEPTH+1)-1:0] cnt_q;
  logic                     do_push, do_pop;

  assign full_o      = (cnt_q == FIFO_DEPTH[$clog2(FIFO_DEPTH+1)-1:0]);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/esds_back.sv
// ----------------------------------------------------------------------------
// esds_back
// Config decoder: unpacks the audio config head of one job and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module esds_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  esds_pkg::job_t    job_i,
  output logic              pop_o,
  esds_out_if.source        out_o
);
  import esds_pkg::*;

  localparam logic [5:0] P_AOT  = 6'd0;
  localparam logic [5:0] P_EXT  = 6'd5;
  localparam logic [5:0] P_SFI  = 6'd5;
  localparam logic [5:0] P_SFIX = 6'd11;
  localparam logic [5:0] P_DEP  = 6'd13;
  localparam logic [5:0] P_SYNC = 6'd16;
  localparam logic [5:0] P_SYNX = 6'd30;

  function automatic logic [15:0] peek(input logic [HEAD_BITS-1:0] h, input logic [5:0] p);
    logic [HEAD_BITS+15:0] t;
    t = {h, 16'h0} << p;
    return t[HEAD_BITS+15 -: 16];
  endfunction

  function automatic logic have(input logic [5:0] last_bit, input logic [LEN_W-1:0] len);
    return LEN_W'(last_bit[5:3]) < len;
  endfunction

  logic        status_d;
  logic [6:0]  aot_d;
  logic [16:0] rate_d;
  logic [1:0]  ch_d;
  logic        sbr_d;
  logic [6:0]  len_d;

  logic [4:0]  a5;
  logic [5:0]  ext;
  logic        esc, ext_ok;
  logic [5:0]  pos, q;
  logic [3:0]  sfi, ch, er5, er;
  logic        sfi_ok, ch_ok, er5_ok, dep_one;
  logic [10:0] sync;
  logic [4:0]  xtype;
  logic        ext_hit;
  logic [16:0] er5_rate, er_rate;
  logic [15:0] pk_aot, pk_ext, pk_sfi, pk_ch, pk_dep, pk_sync, pk_xt, pk_er;
  logic [HEAD_BITS-1:0] h;
  logic [LEN_W-1:0]     n;

  always_comb begin
    h        = job_i.head;
    n        = job_i.len;
    pk_aot   = peek(h, P_AOT);
    a5       = pk_aot[15:11];
    esc      = have(P_AOT + 6'd4, n) && (a5 == AOT_ESCAPE);
    pk_ext   = peek(h, P_EXT);
    ext      = pk_ext[15:10];
    ext_ok   = have(P_EXT + 6'd5, n);
    pos      = esc ? P_SFIX : P_SFI;
    pk_sfi   = peek(h, pos);
    sfi      = pk_sfi[15:12];
    sfi_ok   = have(pos + 6'd3, n);
    pk_ch    = peek(h, pos + 6'd4);
    ch       = pk_ch[15:12];
    ch_ok    = have(pos + 6'd7, n);
    pk_dep   = peek(h, P_DEP);
    er5      = pk_dep[15:12];
    er5_ok   = have(P_DEP + 6'd3, n);
    er5_rate = er5_ok ? rate_of(er5) : 17'd0;
    dep_one  = have(P_DEP, n) && pk_dep[15];
    q        = dep_one ? P_SYNX : P_SYNC;
    pk_sync  = peek(h, q);
    sync     = pk_sync[15:5];
    pk_xt    = peek(h, q + 6'd11);
    xtype    = pk_xt[15:11];
    pk_er    = peek(h, q + 6'd16);
    er       = pk_er[14:11];
    ext_hit  = have(q + 6'd10, n) && (sync == SYNC_EXT)
            && have(q + 6'd15, n) && (xtype == AOT_SBR)
            && have(q + 6'd16, n) && pk_er[15];
    er_rate  = (ext_hit && have(q + 6'd20, n)) ? rate_of(er) : 17'd0;

    status_d = 1'b0;
    aot_d    = '0;
    rate_d   = '0;
    ch_d     = '0;
    sbr_d    = 1'b0;
    len_d    = 7'(n);

    if (!job_i.ok) begin
      status_d = 1'b1;
      len_d    = '0;
    end else if (!(esc && !ext_ok)) begin
      aot_d  = esc ? (7'd32 + 7'(ext)) : (have(P_AOT + 6'd4, n) ? 7'(a5) : 7'd0);
      rate_d = sfi_ok ? rate_of(sfi) : 17'd0;
      ch_d   = !ch_ok ? 2'd0 : (ch > 4'd2) ? 2'd2 : ch[1:0];
      if (!esc && have(P_AOT + 6'd4, n)) begin
        if (a5 == AOT_SBR || a5 == AOT_PS) begin
          if (er5_rate != '0) begin
            rate_d = er5_rate;
            sbr_d  = 1'b1;
          end
        end else if (a5 >= 5'd1 && a5 <= AOT_LC_MAX) begin
          if (er_rate != '0) begin
            rate_d = er_rate;
            sbr_d  = 1'b1;
          end
        end
      end
    end
  end

  assign pop_o = job_valid_i && (!out_o.valid || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (pop_o) begin
      out_o.valid <= 1'b1;
    end else if (out_o.ready) begin
      out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_o.status         <= status_d;
      out_o.object_type    <= aot_d;
      out_o.output_rate_hz <= rate_d;
      out_o.channel_count  <= ch_d;
      out_o.sbr_present    <= sbr_d;
      out_o.config_length  <= len_d;
    end
  end

endmodule

// File: hw/rtl/esds_audio_config_parser.sv
// ----------------------------------------------------------------------------
// esds_audio_config_parser
// Elementary stream descriptor parser with audio specific config decode.
//
//   channel  dir  payload                                    transaction
//   in_i     in   data_byte[7:0], last_byte                  one payload byte
//   out_o    out  status, object_type, output_rate_hz,       one result per
//                 channel_count, sbr_present, config_length   payload
//
// One byte per cycle while the job queue is not full; the byte parser
// registers its state as each byte is taken. A payload's job is written
// into the job queue when its last byte is taken, and the decoder loads its
// output register from the queue head once that register is free. The
// two-entry job queue absorbs output stalls; input stalls only when it is
// full. Reset clears the parser state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module esds_audio_config_parser #(
  parameter int unsigned MAX_CONFIG_BYTES = 64,
  parameter int unsigned MAX_DESCRIPTORS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  esds_in_if.sink    in_i,
  esds_out_if.source out_o
);
  import esds_pkg::*;

  logic byte_fire;
  logic push, full, pop, job_valid;
  job_t push_job, pop_job;

  assign in_i.ready = !full;
  assign byte_fire  = in_i.valid && !full;

  esds_front #(
    .MAX_CONFIG_BYTES (MAX_CONFIG_BYTES),
    .MAX_DESCRIPTORS  (MAX_DESCRIPTORS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (byte_fire),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .push_o      (push),
    .job_o       (push_job)
  );

  esds_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (job_valid),
    .pop_data_o  (pop_job)
  );

  esds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
